>>> hdl/retry_backoff_jitter_policy_core_macros.svh
// Assertion macros used by the checker file of the retry backoff core.
`ifndef RETRY_BACKOFF_JITTER_POLICY_CORE_MACROS_SVH
`define RETRY_BACKOFF_JITTER_POLICY_CORE_MACROS_SVH

// Same-cycle implication, masked during reset.
`define RBJP_ASSERT_IMP(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("rbjp check failed");

// Next-cycle implication, masked during reset.
`define RBJP_ASSERT_NXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("rbjp check failed");

`endif

>>> hdl/rbjp_pkg.sv
// Types and constants of the retry backoff jitter policy core.
package rbjp_pkg;

   localparam int DELAY_W  = 32;
   localparam int COUNT_W  = 16;
   localparam int PCT_W    = 7;
   localparam int STATUS_W = 10;
   localparam int RND_W    = 31;
   localparam int ACTION_W = 2;
   localparam int PROD_W   = DELAY_W + PCT_W;   // delay * percent
   localparam int RANGE_W  = 33;                // (2^32-1)*127/100 fits 33 bits
   localparam int MOD_W    = RANGE_W + 1;       // 2*range + 1
   localparam int SUM_W    = MOD_W + 1;         // delay + pick
   localparam int CNT_W    = 6;                 // counts up to PROD_W-1
   localparam int REM_W    = 7;                 // remainder below 100

   localparam int CSR_INDEX_W = 2;
   localparam int CSR_DATA_W  = 32;

   localparam logic [REM_W:0] PCT_DIV = 8'd100;

   // action codes
   localparam logic [ACTION_W-1:0] ACT_SUCCESS = 2'd0;
   localparam logic [ACTION_W-1:0] ACT_RETRY   = 2'd1;
   localparam logic [ACTION_W-1:0] ACT_GIVEUP  = 2'd2;
   localparam logic [ACTION_W-1:0] ACT_DISCARD = 2'd3;

   // register indexes
   localparam logic [CSR_INDEX_W-1:0] CSR_INITIAL_DELAY = 2'd0;
   localparam logic [CSR_INDEX_W-1:0] CSR_MAX_DELAY     = 2'd1;
   localparam logic [CSR_INDEX_W-1:0] CSR_MAX_RETRIES   = 2'd2;
   localparam logic [CSR_INDEX_W-1:0] CSR_JITTER_PCT    = 2'd3;

   // status values of interest
   localparam logic [STATUS_W-1:0] STATUS_NONE       = 10'd0;
   localparam logic [STATUS_W-1:0] STATUS_OK_LO      = 10'd200;
   localparam logic [STATUS_W-1:0] STATUS_OK_HI      = 10'd300;
   localparam logic [STATUS_W-1:0] STATUS_TIMEOUT    = 10'd408;
   localparam logic [STATUS_W-1:0] STATUS_TOO_MANY   = 10'd429;
   localparam logic [STATUS_W-1:0] STATUS_SERVER_ERR = 10'd500;

   typedef struct packed {
      logic                first_attempt;
      logic                transport_ok;
      logic [STATUS_W-1:0] status_code;
      logic [RND_W-1:0]    random_word;
   } req_type;

   typedef struct packed {
      logic [ACTION_W-1:0] action;
      logic [DELAY_W-1:0]  wait_ms;
      logic [STATUS_W-1:0] status_out;
   } rsp_type;

endpackage

>>> hdl/retry_backoff_jitter_policy_core.sv
// Retry policy core: exponential backoff with jittered wait, one attempt per beat.
// Retry with a non-zero delay: 7 multiply, 39 divide-by-100 and 31 modulo steps,
// each one bit per cycle, then 3 steps to sum, clamp and load the result.
// Other actions go straight to the load step. The next req beat is taken once the load is done.
// A full rsp register holds the sequencer in its load step until taken.
// Synchronous reset clears the state, configuration registers, retry count, delay and rsp valid.
module retry_backoff_jitter_policy_core
   import rbjp_pkg::*;
(
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_valid,
   output logic                   req_ready,
   input  req_type                req_data,
   output logic                   rsp_valid,
   input  logic                   rsp_ready,
   output rsp_type                rsp_data,
   input  logic                   csr_valid,
   output logic                   csr_ready,
   input  logic [CSR_INDEX_W-1:0] csr_index,
   input  logic [CSR_DATA_W-1:0]  csr_data
);

   // sequencer states
   localparam logic [2:0] ST_IDLE = 3'd0;
   localparam logic [2:0] ST_MUL  = 3'd1;   // delay * percent, percent MSB first
   localparam logic [2:0] ST_DIV  = 3'd2;   // product / 100, restoring
   localparam logic [2:0] ST_MOD  = 3'd3;   // random % (2*range+1), restoring
   localparam logic [2:0] ST_SUM  = 3'd4;   // delay + pick
   localparam logic [2:0] ST_FIN  = 3'd5;   // minus range, floor and saturate
   localparam logic [2:0] ST_DONE = 3'd6;   // load rsp register

   // control and configuration
   logic [2:0]          state_ff, state_in;
   logic                rsp_valid_ff, rsp_valid_in;
   logic [DELAY_W-1:0]  init_delay_ff, init_delay_in;
   logic [DELAY_W-1:0]  max_delay_ff, max_delay_in;
   logic [COUNT_W-1:0]  max_retries_ff, max_retries_in;
   logic [PCT_W-1:0]    jitter_pct_ff, jitter_pct_in;
   logic [COUNT_W-1:0]  retry_count_ff, retry_count_in;
   logic [DELAY_W-1:0]  cur_delay_ff, cur_delay_in;

   // datapath shift registers and results
   logic [CNT_W-1:0]    count_ff, count_in;
   logic [PCT_W-1:0]    jp_ff, jp_in;
   logic [DELAY_W-1:0]  delay_ff, delay_in;
   logic [PROD_W-1:0]   acc_ff, acc_in;      // product, then quotient (range)
   logic [REM_W-1:0]    rem_ff, rem_in;
   logic [RND_W-1:0]    rnd_ff, rnd_in;
   logic [MOD_W-1:0]    mrem_ff, mrem_in;
   logic [SUM_W-1:0]    sum_ff, sum_in;
   logic [ACTION_W-1:0] action_ff, action_in;
   logic [STATUS_W-1:0] status_ff, status_in;
   logic [DELAY_W-1:0]  wait_ff, wait_in;
   rsp_type             rsp_data_ff, rsp_data_in;

   // decision terms
   logic                req_fire;
   logic [STATUS_W-1:0] st_eff;
   logic                is_2xx;
   logic                retryable;
   logic [COUNT_W-1:0]  cnt_eff;
   logic [DELAY_W-1:0]  dly_eff;
   logic [DELAY_W:0]    dly_dbl;
   logic [DELAY_W-1:0]  dly_sat;
   logic [DELAY_W-1:0]  dly_next;
   logic [ACTION_W-1:0] act_dec;

   // step terms
   logic [REM_W:0]      div_t;
   logic                div_ge;
   logic [MOD_W-1:0]    modulus;
   logic [MOD_W:0]      mod_t;
   logic                mod_ge;
   logic [SUM_W-1:0]    range_ext;
   logic [SUM_W-1:0]    diff;

   assign req_ready = (state_ff == ST_IDLE);
   assign csr_ready = 1'b1;
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;
   assign req_fire  = req_valid && req_ready;

   // Classification and state update for the accepted attempt.
   always_comb begin
      st_eff    = req_data.transport_ok ? req_data.status_code : STATUS_NONE;
      is_2xx    = req_data.transport_ok && (st_eff >= STATUS_OK_LO) && (st_eff < STATUS_OK_HI);
      retryable = (st_eff == STATUS_NONE) || (st_eff == STATUS_TIMEOUT) ||
                  (st_eff == STATUS_TOO_MANY) || (st_eff >= STATUS_SERVER_ERR);
      cnt_eff   = req_data.first_attempt ? '0 : retry_count_ff;
      dly_eff   = req_data.first_attempt ? init_delay_ff : cur_delay_ff;
      // doubled delay, saturated at 32 bits, then capped when a cap is set
      dly_dbl   = {dly_eff, 1'b0};
      dly_sat   = dly_dbl[DELAY_W] ? '1 : dly_dbl[DELAY_W-1:0];
      dly_next  = ((max_delay_ff != '0) && (dly_sat > max_delay_ff)) ? max_delay_ff : dly_sat;
      if (is_2xx) begin
         act_dec = ACT_SUCCESS;
      end else if (retryable) begin
         act_dec = (cnt_eff >= max_retries_ff) ? ACT_GIVEUP : ACT_RETRY;
      end else begin
         act_dec = ACT_DISCARD;
      end
   end

   // Bit-serial steps.
   always_comb begin
      div_t     = {rem_ff, acc_ff[PROD_W-1]};
      div_ge    = (div_t >= PCT_DIV);
      modulus   = {acc_ff[RANGE_W-1:0], 1'b1};
      mod_t     = {mrem_ff, rnd_ff[RND_W-1]};
      mod_ge    = (mod_t >= {1'b0, modulus});
      range_ext = {{(SUM_W-RANGE_W){1'b0}}, acc_ff[RANGE_W-1:0]};
      diff      = sum_ff - range_ext;
   end

   always_comb begin
      state_in       = state_ff;
      rsp_valid_in   = rsp_valid_ff && !rsp_ready;
      init_delay_in  = init_delay_ff;
      max_delay_in   = max_delay_ff;
      max_retries_in = max_retries_ff;
      jitter_pct_in  = jitter_pct_ff;
      retry_count_in = retry_count_ff;
      cur_delay_in   = cur_delay_ff;
      count_in       = count_ff;
      jp_in          = jp_ff;
      delay_in       = delay_ff;
      acc_in         = acc_ff;
      rem_in         = rem_ff;
      rnd_in         = rnd_ff;
      mrem_in        = mrem_ff;
      sum_in         = sum_ff;
      action_in      = action_ff;
      status_in      = status_ff;
      wait_in        = wait_ff;
      rsp_data_in    = rsp_data_ff;

      if (csr_valid && csr_ready) begin
         case (csr_index)
            CSR_INITIAL_DELAY: init_delay_in  = csr_data[DELAY_W-1:0];
            CSR_MAX_DELAY:     max_delay_in   = csr_data[DELAY_W-1:0];
            CSR_MAX_RETRIES:   max_retries_in = csr_data[COUNT_W-1:0];
            CSR_JITTER_PCT:    jitter_pct_in  = csr_data[PCT_W-1:0];
            default: ;
         endcase
      end

      case (state_ff)
         ST_IDLE: begin
            if (req_fire) begin
               action_in      = act_dec;
               status_in      = st_eff;
               wait_in        = '0;
               retry_count_in = cnt_eff;
               cur_delay_in   = dly_eff;
               delay_in       = dly_eff;
               jp_in          = jitter_pct_ff;
               rnd_in         = req_data.random_word;
               acc_in         = '0;
               count_in       = CNT_W'(PCT_W - 1);
               state_in       = ST_DONE;
               if (act_dec == ACT_RETRY) begin
                  retry_count_in = cnt_eff + 1'b1;
                  if (dly_eff != '0) begin
                     cur_delay_in = dly_next;
                     state_in     = ST_MUL;
                  end
               end
            end
         end
         ST_MUL: begin
            acc_in   = {acc_ff[PROD_W-2:0], 1'b0} +
                       (jp_ff[PCT_W-1] ? {{PCT_W{1'b0}}, delay_ff} : '0);
            jp_in    = {jp_ff[PCT_W-2:0], 1'b0};
            count_in = count_ff - 1'b1;
            if (count_ff == '0) begin
               rem_in   = '0;
               count_in = CNT_W'(PROD_W - 1);
               state_in = ST_DIV;
            end
         end
         ST_DIV: begin
            rem_in   = div_ge ? REM_W'(div_t - PCT_DIV) : div_t[REM_W-1:0];
            acc_in   = {acc_ff[PROD_W-2:0], div_ge};
            count_in = count_ff - 1'b1;
            if (count_ff == '0) begin
               mrem_in  = '0;
               count_in = CNT_W'(RND_W - 1);
               state_in = ST_MOD;
            end
         end
         ST_MOD: begin
            mrem_in  = mod_ge ? MOD_W'(mod_t - {1'b0, modulus}) : mod_t[MOD_W-1:0];
            rnd_in   = {rnd_ff[RND_W-2:0], 1'b0};
            count_in = count_ff - 1'b1;
            if (count_ff == '0) begin
               state_in = ST_SUM;
            end
         end
         ST_SUM: begin
            sum_in   = {{(SUM_W-DELAY_W){1'b0}}, delay_ff} + {1'b0, mrem_ff};
            state_in = ST_FIN;
         end
         ST_FIN: begin
            // negative wait floors at 0, anything past 32 bits saturates
            if (sum_ff <= range_ext) begin
               wait_in = '0;
            end else if (diff[SUM_W-1:DELAY_W] != '0) begin
               wait_in = '1;
            end else begin
               wait_in = diff[DELAY_W-1:0];
            end
            state_in = ST_DONE;
         end
         ST_DONE: begin
            if (!rsp_valid_ff || rsp_ready) begin
               rsp_data_in.action     = action_ff;
               rsp_data_in.wait_ms    = wait_ff;
               rsp_data_in.status_out = status_ff;
               rsp_valid_in           = 1'b1;
               state_in               = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff       <= ST_IDLE;
         rsp_valid_ff   <= 1'b0;
         init_delay_ff  <= '0;
         max_delay_ff   <= '0;
         max_retries_ff <= '0;
         jitter_pct_ff  <= '0;
         retry_count_ff <= '0;
         cur_delay_ff   <= '0;
      end else begin
         state_ff       <= state_in;
         rsp_valid_ff   <= rsp_valid_in;
         init_delay_ff  <= init_delay_in;
         max_delay_ff   <= max_delay_in;
         max_retries_ff <= max_retries_in;
         jitter_pct_ff  <= jitter_pct_in;
         retry_count_ff <= retry_count_in;
         cur_delay_ff   <= cur_delay_in;
      end
   end

   // payload, no reset needed
   always_ff @(posedge clock) begin
      count_ff    <= count_in;
      jp_ff       <= jp_in;
      delay_ff    <= delay_in;
      acc_ff      <= acc_in;
      rem_ff      <= rem_in;
      rnd_ff      <= rnd_in;
      mrem_ff     <= mrem_in;
      sum_ff      <= sum_in;
      action_ff   <= action_in;
      status_ff   <= status_in;
      wait_ff     <= wait_in;
      rsp_data_ff <= rsp_data_in;
   end

endmodule

>>> hdl/rbjp_checker.sv
// Port-level checks of the retry backoff core, bound to the top level.
`include "retry_backoff_jitter_policy_core_macros.svh"

module rbjp_checker
   import rbjp_pkg::*;
(
   input logic                   clock,
   input logic                   reset,
   input logic                   req_valid,
   input logic                   req_ready,
   input req_type                req_data,
   input logic                   rsp_valid,
   input logic                   rsp_ready,
   input rsp_type                rsp_data,
   input logic                   csr_valid,
   input logic                   csr_ready,
   input logic [CSR_INDEX_W-1:0] csr_index,
   input logic [CSR_DATA_W-1:0]  csr_data
);

   logic unused_ok;
   assign unused_ok = ^{req_data, csr_valid, csr_ready, csr_index, csr_data};

   // a stalled result beat holds
   `RBJP_ASSERT_NXT(a_rsp_hold, clock, reset, rsp_valid && !rsp_ready, rsp_valid && $stable(rsp_data))

   // one attempt in flight at a time
   `RBJP_ASSERT_NXT(a_one_in_flight, clock, reset, req_valid && req_ready, !req_ready)

   // only a retry carries a wait
   `RBJP_ASSERT_IMP(a_wait_retry_only, clock, reset, rsp_valid && (rsp_data.action != ACT_RETRY), rsp_data.wait_ms == '0)

   // success only on a 2xx status
   `RBJP_ASSERT_IMP(a_success_2xx, clock, reset, rsp_valid && (rsp_data.action == ACT_SUCCESS), (rsp_data.status_out >= STATUS_OK_LO) && (rsp_data.status_out < STATUS_OK_HI))

endmodule

bind retry_backoff_jitter_policy_core rbjp_checker u_rbjp_checker (.*);
